/* rtl/sftr_pkg.sv */
// sftr_pkg: shared types and constants of the sparse table range finder
// used by every module under rtl/; depends on nothing else
package sftr_pkg;

	localparam int POS_W          = 31;
	localparam int GAP_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [POS_W-1:0] LOW_LIMIT      = POS_W'(255);
	localparam logic [GAP_W-1:0] GAP_RESET      = GAP_W'(256);
	localparam logic [POS_W-1:0] ADJACENT_GAP   = POS_W'(1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FORCED_LOW    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GAP_THRESHOLD = CFG_IDX_W'(1);

	// classified table entry, front to back
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             active;
		logic             fin;
	} item_t;

	// one emitted range
	typedef struct packed {
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] stop;
		logic             last;
	} range_t;

endpackage

/* rtl/sparse_table_range_finder_top.sv */
// sparse_table_range_finder_top: top level, configuration registers and wiring
// depends on sftr_pkg, sftr_front, sftr_queue, sftr_back
//
// takes table entries one per cycle in ascending position order and emits
// merged ranges of active entries; an entry passes the front register
// (classification), a queue of QUEUE_DEPTH entries and the back stage
// (range merging plus a two-entry output buffer), where its range is
// registered; sustained rate is one entry per cycle while the sink takes
// ranges, set by the back stage taking one queued entry a cycle; an entry
// that both closes a range and is final yields two ranges and waits in the
// queue until the output buffer is empty; configuration writes are taken
// at once and are meant for an idle block
module sparse_table_range_finder_top #(
	parameter int QUEUE_DEPTH = sftr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// entry transactions
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sftr_pkg::POS_W-1:0]      position,
	input  logic [sftr_pkg::POS_W-1:0]      mapped_value,
	input  logic                            final_entry,
	// range transactions
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sftr_pkg::POS_W-1:0]      range_start,
	output logic [sftr_pkg::POS_W-1:0]      range_end,
	output logic                            last_range,
	// configuration write transactions
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sftr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sftr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sftr_pkg::*;

	logic             forced_low_q;
	logic [GAP_W-1:0] gap_threshold_q;

	logic   push_valid;
	logic   push_ready;
	item_t  push_item;
	logic   q_valid;
	logic   q_ready;
	item_t  q_item;
	range_t out_range;

	// writes are always accepted at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forced_low_q    <= 1'b0;
			gap_threshold_q <= GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FORCED_LOW: begin
					forced_low_q <= cfg_data[0];
				end
				REG_GAP_THRESHOLD: begin
					gap_threshold_q <= cfg_data[GAP_W-1:0];
				end
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// front: register and classify
	sftr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.forced_low   (forced_low_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.position     (position),
		.mapped_value (mapped_value),
		.final_entry  (final_entry),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	// decoupling queue
	sftr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// back: merge ranges and buffer results
	sftr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.gap_threshold (gap_threshold_q),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_range     (out_range)
	);

	assign range_start = out_range.start;
	assign range_end   = out_range.stop;
	assign last_range  = out_range.last;

endmodule

/* rtl/sftr_front.sv */
// sftr_front: input register that classifies each table entry as active
// depends on sftr_pkg
module sftr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       forced_low,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sftr_pkg::POS_W-1:0] position,
	input  logic [sftr_pkg::POS_W-1:0] mapped_value,
	input  logic                       final_entry,
	output logic                       push_valid,
	input  logic                       push_ready,
	output sftr_pkg::item_t            push_item
);
	import sftr_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;

	always_comb begin
		item_d.pos    = position;
		item_d.active = (mapped_value != position) || (forced_low && (position <= LOW_LIMIT));
		item_d.fin    = final_entry;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* rtl/sftr_queue.sv */
// sftr_queue: small fifo of classified entries between front and back
// depends on sftr_pkg
module sftr_queue #(
	parameter int DEPTH = sftr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sftr_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sftr_pkg::item_t pop_item
);
	import sftr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/sftr_back.sv */
// sftr_back: range merging state and two-entry output buffer
// depends on sftr_pkg
module sftr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [sftr_pkg::GAP_W-1:0] gap_threshold,
	input  logic                       q_valid,
	output logic                       q_ready,
	input  sftr_pkg::item_t            q_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output sftr_pkg::range_t           out_range
);
	import sftr_pkg::*;

	logic             pend_valid_q;
	logic [POS_W-1:0] pend_start_q;
	logic [POS_W-1:0] pend_end_q;
	logic [POS_W-1:0] first_pos_q;
	logic             seen_q;

	logic             pend_valid_d;
	logic [POS_W-1:0] pend_start_d;
	logic [POS_W-1:0] pend_end_d;
	logic [POS_W-1:0] first_pos_d;

	logic [POS_W-1:0] gap;
	logic             merge;
	logic             emit0;
	logic [1:0]       n_push;
	logic             take;
	range_t           r0;
	range_t           r1;
	range_t           pa;

	range_t           slot0_q;
	range_t           slot1_q;
	logic [1:0]       cnt_q;
	range_t           slot0_d;
	range_t           slot1_d;
	logic [1:0]       cnt_d;
	logic             pop;

	// modulo 2^31 distance from the open range end
	assign gap   = q_item.pos - pend_end_q;
	assign merge = (gap == ADJACENT_GAP) || (gap < {{(POS_W-GAP_W){1'b0}}, gap_threshold});
	assign emit0 = q_item.active && pend_valid_q && !merge;

	always_comb begin
		pend_valid_d = pend_valid_q;
		pend_start_d = pend_start_q;
		pend_end_d   = pend_end_q;
		first_pos_d  = seen_q ? first_pos_q : q_item.pos;
		if (q_item.active) begin
			if (pend_valid_q && merge) begin
				pend_end_d = q_item.pos;
			end else begin
				pend_valid_d = 1'b1;
				pend_start_d = q_item.pos;
				pend_end_d   = q_item.pos;
			end
		end
	end

	always_comb begin
		r0.start = pend_start_q;
		r0.stop  = pend_end_q;
		r0.last  = 1'b0;
		// nothing active: one range spans the whole table
		r1.start = pend_valid_d ? pend_start_d : first_pos_d;
		r1.stop  = pend_valid_d ? pend_end_d : q_item.pos;
		r1.last  = 1'b1;
		pa       = emit0 ? r0 : r1;
	end

	assign n_push = {1'b0, emit0} + {1'b0, q_item.fin};
	// room is judged before this cycle's pop to keep out_ready off the queue path
	assign q_ready = (n_push == 2'd0) || (n_push == 2'd1 && cnt_q != 2'd2) || (cnt_q == 2'd0);
	assign take    = q_valid && q_ready;

	assign out_valid = (cnt_q != 2'd0);
	assign out_range = slot0_q;
	assign pop       = out_valid && out_ready;

	always_comb begin
		slot0_d = slot0_q;
		slot1_d = slot1_q;
		cnt_d   = cnt_q;
		if (pop) begin
			slot0_d = slot1_q;
			cnt_d   = cnt_q - 2'd1;
		end
		if (take && n_push != 2'd0) begin
			if (cnt_d == 2'd0) begin
				slot0_d = pa;
			end else begin
				slot1_d = pa;
			end
			if (n_push == 2'd2) begin
				slot1_d = r1;
			end
			cnt_d = cnt_d + n_push;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_start_q <= '0;
			pend_end_q   <= '0;
			first_pos_q  <= '0;
			seen_q       <= 1'b0;
			cnt_q        <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
			if (take) begin
				if (q_item.fin) begin
					pend_valid_q <= 1'b0;
					pend_start_q <= '0;
					pend_end_q   <= '0;
					first_pos_q  <= '0;
					seen_q       <= 1'b0;
				end else begin
					pend_valid_q <= pend_valid_d;
					pend_start_q <= pend_start_d;
					pend_end_q   <= pend_end_d;
					first_pos_q  <= first_pos_d;
					seen_q       <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_two_need_empty: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit0 && q_item.fin |-> cnt_q == 2'd0)
		else $error("two ranges pushed into a non-empty buffer");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && q_item.fin |=> !pend_valid_q && !seen_q)
		else $error("table state not cleared after final entry");

	a_active_opens: assert property (@(posedge clk) disable iff (!arst_n)
		take && q_item.active && !q_item.fin |=> pend_valid_q && pend_end_q == $past(q_item.pos))
		else $error("active entry did not become the range end");

endmodule

/* bench/sparse_table_range_finder_top_tb.sv */
// sparse_table_range_finder_top_tb: self-checking bench for the sparse table range finder
// drives entry and configuration transactions, predicts ranges in-bench, checks every range
// depends on sftr_pkg and sparse_table_range_finder_top from rtl/
`timescale 1ns / 1ps

module sparse_table_range_finder_top_tb;

	import sftr_pkg::*;

	localparam int          CLK_HALF    = 2;
	localparam int          RESET_LEN   = 11;
	// pipeline is front reg + queue + back stage + output buffer, so this is plenty
	localparam int          DRAIN_TAIL  = 16;
	localparam int          REPORT_MAX  = 10;
	localparam int          PHASE_ITEMS = 170;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// index outside the register map, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(3);

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [POS_W-1:0]      position = '0;
	logic [POS_W-1:0]      mapped_value = '0;
	logic                  final_entry = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [POS_W-1:0]      range_start;
	logic [POS_W-1:0]      range_end;
	logic                  last_range;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predicted configuration, mirrors the reset values of the block
	logic             forced_low = 1'b0;
	logic [GAP_W-1:0] gap_limit = GAP_RESET;

	// predicted range state of the table being streamed
	logic             open_range = 1'b0;
	logic [POS_W-1:0] open_start = '0;
	logic [POS_W-1:0] open_stop = '0;
	logic [POS_W-1:0] first_pos = '0;
	logic             seen_entry = 1'b0;

	range_t expected_ranges[$];

	int unsigned errors = 0;
	int unsigned entries_sent = 0;
	int unsigned ranges_checked = 0;
	int unsigned tables_sent = 0;
	int unsigned cfg_writes = 0;
	int unsigned cycle_count = 0;
	int unsigned sink_wait = 0;
	// when set, both sides run back to back with no idle cycles
	logic        calm = 1'b0;

	sparse_table_range_finder_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.position     (position),
		.mapped_value (mapped_value),
		.final_entry  (final_entry),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.range_start  (range_start),
		.range_end    (range_end),
		.last_range   (last_range),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// run-away guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d ranges still awaited",
				cycle_count, expected_ranges.size());
			$display("Verification failed");
			$finish;
		end
	end

	// idle cycles before an entry or before taking a range
	function automatic int unsigned draw_wait();
		if (calm)
			return 0;
		case ($urandom_range(0, 3))
			0: return 0;
			1: return $urandom_range(0, 2);
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	// range merging of one accepted entry; pushes the ranges it closes
	task automatic merge_entry(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] val,
	                           input logic fin);
		logic             active;
		logic [POS_W-1:0] gap_dist;
		range_t           r;
		if (!seen_entry) begin
			first_pos  = pos;
			seen_entry = 1'b1;
		end
		active = (val != pos) || (forced_low && pos <= LOW_LIMIT);
		if (active) begin
			if (open_range) begin
				// distance wraps at 31 bits, so a step backward looks far away
				gap_dist = pos - open_stop;
				if (gap_dist == ADJACENT_GAP || gap_dist < POS_W'(gap_limit)) begin
					open_stop = pos;
				end else begin
					r = '{start: open_start, stop: open_stop, last: 1'b0};
					expected_ranges.push_back(r);
					open_start = pos;
					open_stop  = pos;
				end
			end else begin
				open_range = 1'b1;
				open_start = pos;
				open_stop  = pos;
			end
		end
		if (fin) begin
			// nothing active: the whole table comes back as one range
			if (open_range)
				r = '{start: open_start, stop: open_stop, last: 1'b1};
			else
				r = '{start: first_pos, stop: pos, last: 1'b1};
			expected_ranges.push_back(r);
			open_range = 1'b0;
			open_start = '0;
			open_stop  = '0;
			first_pos  = '0;
			seen_entry = 1'b0;
		end
	endtask

	// entry side: predict on every accepted transaction
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			merge_entry(position, mapped_value, final_entry);
	end

	// range side: stall pattern, changes only at the falling edge
	always @(negedge clk) begin
		if (sink_wait > 0) begin
			out_ready <= 1'b0;
			sink_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// range side: compare each accepted range with the oldest prediction
	always @(posedge clk) begin
		range_t want;
		range_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{start: range_start, stop: range_end, last: last_range};
			if (expected_ranges.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: unexpected range start=%0h end=%0h last=%0b",
						$realtime, got.start, got.stop, got.last);
			end else begin
				want = expected_ranges.pop_front();
				ranges_checked++;
				if (got !== want) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display({"%0t: range mismatch exp start=%0h end=%0h last=%0b,",
							" got start=%0h end=%0h last=%0b"},
							$realtime, want.start, want.stop, want.last,
							got.start, got.stop, got.last);
				end
			end
			sink_wait = draw_wait();
		end
	end

	// one entry transaction; called and returning at a falling edge
	task automatic send_entry(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] val,
	                          input logic fin);
		int unsigned idle;
		idle = draw_wait();
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		in_valid     <= 1'b1;
		position     <= pos;
		mapped_value <= val;
		final_entry  <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		entries_sent++;
		if (fin)
			tables_sent++;
		@(negedge clk);
	endtask

	// one configuration write, only while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_FORCED_LOW:    forced_low = data[0];
			REG_GAP_THRESHOLD: gap_limit  = data[GAP_W-1:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// every predicted range has come back and the pipeline has emptied
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_ranges.size() != 0) @(negedge clk);
		repeat (DRAIN_TAIL) @(negedge clk);
	endtask

	function automatic logic [POS_W-1:0] other_value(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] v;
		if ($urandom_range(0, 3) == 0)
			v = pos ^ (POS_W'(1) << $urandom_range(0, POS_W - 1));
		else
			v = POS_W'($urandom);
		if (v == pos)
			v = ~pos;
		return v;
	endfunction

	// one table of entries, mostly consecutive, with jumps and the odd stray position
	task automatic send_table(input int unsigned len, input logic [POS_W-1:0] base,
	                          input int unsigned density, input int unsigned max_jump);
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] val;
		int unsigned      i;
		pos = base;
		for (i = 0; i < len; i++) begin
			if (i != 0) begin
				case ($urandom_range(0, 29))
					0, 1, 2, 3: pos = pos + POS_W'($urandom_range(2, max_jump));
					4:          pos = POS_W'($urandom);
					5:          pos = pos - POS_W'($urandom_range(0, 3));
					default:    pos = pos + POS_W'(1);
				endcase
			end
			if ($urandom_range(1, 100) <= density)
				val = other_value(pos);
			else
				val = pos;
			send_entry(pos, val, i == len - 1);
		end
	endtask

	// default registers: idle tables, a single-entry table at the top position, two ranges
	// from one entry and positions that step backward
	task automatic test_reset_defaults();
		send_entry(POS_W'(10), POS_W'(10), 1'b0);
		send_entry(POS_W'(11), POS_W'(11), 1'b0);
		send_entry(POS_W'(12), POS_W'(12), 1'b1);
		send_entry({POS_W{1'b1}}, '0, 1'b1);
		send_entry('0, POS_W'(5), 1'b0);
		send_entry(POS_W'(255), '0, 1'b0);
		send_entry(POS_W'(511), POS_W'(1), 1'b1);
		send_entry(POS_W'(100), '0, 1'b0);
		send_entry(POS_W'(100), POS_W'(1), 1'b0);
		send_entry(POS_W'(50), '0, 1'b0);
		send_entry(POS_W'(51), POS_W'(51), 1'b1);
		wait_drained();
	endtask

	// low positions forced active; upper data bits of the mode write are don't care
	task automatic test_forced_low();
		write_reg(REG_FORCED_LOW, 16'hFFFF);
		send_entry(POS_W'(254), POS_W'(254), 1'b0);
		send_entry(POS_W'(255), POS_W'(255), 1'b0);
		send_entry(POS_W'(256), POS_W'(256), 1'b0);
		send_entry(POS_W'(257), POS_W'(257), 1'b1);
		send_entry('0, '0, 1'b1);
		send_entry(POS_W'(256), POS_W'(256), 1'b1);
		wait_drained();
	endtask

	// threshold extremes, including values below the adjacent step
	task automatic test_gap_extremes();
		write_reg(REG_FORCED_LOW, 16'hFFFE);
		write_reg(REG_GAP_THRESHOLD, 16'h0000);
		send_entry(POS_W'(5), '0, 1'b0);
		send_entry(POS_W'(6), '0, 1'b0);
		send_entry(POS_W'(6), POS_W'(1), 1'b0);
		send_entry(POS_W'(8), '0, 1'b1);
		wait_drained();
		write_reg(REG_GAP_THRESHOLD, 16'h0001);
		send_entry(POS_W'(20), '0, 1'b0);
		send_entry(POS_W'(21), '0, 1'b0);
		send_entry(POS_W'(23), '0, 1'b1);
		wait_drained();
		write_reg(REG_GAP_THRESHOLD, 16'hFFFF);
		write_reg(REG_UNMAPPED, 16'h0003);
		send_entry('0, POS_W'(7), 1'b0);
		send_entry(POS_W'(65534), '0, 1'b0);
		send_entry(POS_W'(131069), '0, 1'b0);
		send_entry(POS_W'(131070), POS_W'(131070), 1'b1);
		send_entry(POS_W'(1000), '0, 1'b0);
		send_entry(POS_W'(32'h4100_0000), '0, 1'b1);
		wait_drained();
	endtask

	// random tables under a series of register settings
	task automatic test_random_tables();
		logic             mode_set[6];
		logic [GAP_W-1:0] gap_set[6];
		int unsigned      p;
		int unsigned      start_count;
		int unsigned      len;
		int unsigned      mj;
		logic [POS_W-1:0] base;
		mode_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
		gap_set  = '{16'd2, 16'd3, GAP_W'($urandom_range(2, 20)), GAP_RESET, 16'hFFFF,
		             GAP_W'($urandom_range(2, 65535))};
		mode_set[5] = $urandom_range(0, 1);
		for (p = 0; p < 6; p++) begin
			write_reg(REG_FORCED_LOW, {CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)} | mode_set[p]);
			write_reg(REG_GAP_THRESHOLD, gap_set[p]);
			mj = 2 + 2 * gap_set[p];
			start_count = entries_sent;
			while (entries_sent - start_count < PHASE_ITEMS) begin
				calm = ($urandom_range(0, 3) == 0);
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
				case ($urandom_range(0, 3))
					0:       base = POS_W'($urandom_range(0, 300));
					1:       base = POS_W'($urandom);
					2:       base = {POS_W{1'b1}} - POS_W'($urandom_range(0, 40));
					default: base = POS_W'($urandom_range(0, 5000));
				endcase
				send_table(len, base, $urandom_range(5, 95), mj);
			end
			calm = 1'b0;
			wait_drained();
		end
	endtask

	initial begin
		repeat (RESET_LEN) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_forced_low();
		test_gap_extremes();
		test_random_tables();

		wait_drained();
		if (expected_ranges.size() != 0)
			errors++;
		$display("covered %0d entries in %0d tables, %0d ranges checked, %0d register writes",
			entries_sent, tables_sent, ranges_checked, cfg_writes);
		$display("errors: %0d", errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
